// File: hw/rtl/ddcrfc_pkg.sv
package ddcrfc_pkg;

    localparam logic [7:0] C_SEED_XOR = 8'h50;
    localparam logic [7:0] C_BUSY_A   = 8'h51;
    localparam logic [7:0] C_BUSY_B   = 8'hFF;
    localparam logic [7:0] C_LEN_FLAG = 8'h80;
    localparam logic [6:0] C_MAX_LEN  = 7'd127;

    localparam logic [6:0] C_DEV_ADDR_RST      = 7'd55;
    localparam logic [6:0] C_PAYLOAD_LIMIT_RST = 7'd8;

    // configuration register indexes
    localparam logic C_REG_DEVICE_ADDRESS = 1'b0;
    localparam logic C_REG_PAYLOAD_LIMIT  = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LENGTH,
        PH_PAYLOAD,
        PH_CHECK,
        PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BUSY       = 3'd1,
        ST_BAD_SOURCE = 3'd2,
        ST_NO_FLAG    = 3'd3,
        ST_TOO_LONG   = 3'd4,
        ST_CHECKSUM   = 3'd5
    } t_status;

    typedef struct packed {
        logic [6:0] device_address;
        logic [6:0] payload_limit;
    } t_cfg_regs;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_status;
        logic [2:0] status;
        logic [6:0] payload_count;
    } t_result;

endpackage

// File: hw/rtl/ddcrfc_ifs.sv
interface ddcrfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface ddcrfc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_status;
    logic [2:0] status;
    logic [6:0] payload_count;

    modport source (output valid, output out_byte, output is_status, output status,
                    output payload_count, input ready);
    modport sink   (input valid, input out_byte, input is_status, input status,
                    input payload_count, output ready);
endinterface

interface ddcrfc_cfg_if;
    logic       valid;
    logic       ready;
    logic       reg_index;
    logic [7:0] wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// File: hw/rtl/ddcrfc_frame_fsm.sv
module ddcrfc_frame_fsm
    import ddcrfc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_rx_byte,
    input  logic       i_frame_start,
    input  t_cfg_regs  i_cfg,
    output logic       o_res_valid,
    output t_result    o_res
);

    t_phase     r_phase, n_phase;
    logic [7:0] r_xor, n_xor;
    logic [6:0] r_left, n_left;
    logic [6:0] r_len, n_len;

    logic       busy_src;
    logic       src_ok;
    logic [6:0] len_field;
    logic       len_flag;
    logic       too_long;
    logic [7:0] xor_b;
    logic [6:0] left_dec;

    assign busy_src  = (i_rx_byte == C_BUSY_A) || (i_rx_byte == C_BUSY_B);
    assign src_ok    = (i_rx_byte == {i_cfg.device_address, 1'b0});
    assign len_field = i_rx_byte[6:0];
    assign len_flag  = (i_rx_byte & C_LEN_FLAG) != 8'h00;
    assign too_long  = (len_field > i_cfg.payload_limit) || (len_field > C_MAX_LEN);
    assign xor_b     = r_xor ^ i_rx_byte;
    assign left_dec  = r_left - 7'd1;

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (i_frame_start) begin
            n_phase = (busy_src || !src_ok) ? PH_DONE : PH_LENGTH;
        end else begin
            unique case (r_phase)
                PH_LENGTH: begin
                    if (!len_flag || too_long) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_phase = (len_field == 7'd0) ? PH_CHECK : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    if (left_dec == 7'd0) begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: n_phase = PH_DONE;
                PH_IDLE,
                PH_DONE:  n_phase = r_phase;
                default:  n_phase = PH_IDLE;
            endcase
        end
    end

    // datapath and result
    always_comb begin
        n_xor       = r_xor;
        n_left      = r_left;
        n_len       = r_len;
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_frame_start) begin
            n_xor  = C_SEED_XOR;
            n_left = 7'd0;
            n_len  = 7'd0;
            if (busy_src) begin
                o_res_valid     = 1'b1;
                o_res.is_status = 1'b1;
                o_res.status    = ST_BUSY;
            end else if (!src_ok) begin
                o_res_valid     = 1'b1;
                o_res.is_status = 1'b1;
                o_res.status    = ST_BAD_SOURCE;
            end else begin
                n_xor = C_SEED_XOR ^ i_rx_byte;
            end
        end else begin
            unique case (r_phase)
                PH_LENGTH: begin
                    if (!len_flag) begin
                        o_res_valid         = 1'b1;
                        o_res.is_status     = 1'b1;
                        o_res.status        = ST_NO_FLAG;
                        o_res.payload_count = len_field;
                    end else if (too_long) begin
                        o_res_valid         = 1'b1;
                        o_res.is_status     = 1'b1;
                        o_res.status        = ST_TOO_LONG;
                        o_res.payload_count = len_field;
                    end else begin
                        n_xor  = xor_b;
                        n_len  = len_field;
                        n_left = len_field;
                    end
                end
                PH_PAYLOAD: begin
                    n_xor          = xor_b;
                    n_left         = left_dec;
                    o_res_valid    = 1'b1;
                    o_res.out_byte = i_rx_byte;
                end
                PH_CHECK: begin
                    n_xor               = xor_b;
                    o_res_valid         = 1'b1;
                    o_res.is_status     = 1'b1;
                    o_res.status        = (xor_b == 8'h00) ? ST_OK : ST_CHECKSUM;
                    o_res.payload_count = r_len;
                end
                PH_IDLE,
                PH_DONE: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_xor   <= C_SEED_XOR;
            r_left  <= 7'd0;
            r_len   <= 7'd0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_xor   <= n_xor;
            r_left  <= n_left;
            r_len   <= n_len;
        end
    end

endmodule

// File: hw/rtl/ddc_ci_reply_frame_checker.sv
// Channel  Dir  Handshake    Payload
// i_in     in   valid/ready  rx_byte[7:0], frame_start
// o_out    out  valid/ready  out_byte[7:0], is_status, status[2:0], payload_count[6:0]
// i_cfg    in   valid/ready  reg_index, wr_data[7:0] (low 7 bits kept)
//
// One item per cycle while the result side keeps ready high; an accepted item
// passes through the input register, then the result register.
// Synchronous active-low reset: parser idle, seed 0x50, registers at 55 and 8.
// A stalled result freezes both registers: the input register takes at most
// one item while the result waits, and that item stays put until it drains.
// Config port always ready; user must write it only while block idle (unenforced).
module ddc_ci_reply_frame_checker
    import ddcrfc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    ddcrfc_in_if.sink    i_in,
    ddcrfc_out_if.source o_out,
    ddcrfc_cfg_if.sink   i_cfg
);

    // config registers
    t_cfg_regs r_cfg;

    // input stage
    logic       r_s1_valid;
    logic [7:0] r_s1_byte;
    logic       r_s1_start;

    // result stage
    logic    r_out_valid;
    t_result r_out;

    logic    can_move;
    logic    step;
    logic    res_valid;
    t_result res;

    // stage 1 moves whenever the result slot is empty or being drained
    assign can_move   = !r_out_valid || o_out.ready;
    assign step       = r_s1_valid && can_move;
    assign i_in.ready = !r_s1_valid || can_move;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_address <= C_DEV_ADDR_RST;
            r_cfg.payload_limit  <= C_PAYLOAD_LIMIT_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.reg_index)
                C_REG_DEVICE_ADDRESS: r_cfg.device_address <= i_cfg.wr_data[6:0];
                C_REG_PAYLOAD_LIMIT:  r_cfg.payload_limit  <= i_cfg.wr_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_s1_byte  <= i_in.rx_byte;
            r_s1_start <= i_in.frame_start;
        end
    end

    ddcrfc_frame_fsm u_fsm (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_rx_byte     (r_s1_byte),
        .i_frame_start (r_s1_start),
        .i_cfg         (r_cfg),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    // items that give no result just retire without touching the result slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (can_move) begin
            r_out_valid <= step && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.out_byte      = r_out.out_byte;
    assign o_out.is_status     = r_out.is_status;
    assign o_out.status        = r_out.status;
    assign o_out.payload_count = r_out.payload_count;

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ddcrfc_pkg::*;

    localparam int WATCHDOG_LIMIT = 500;  // cycles with no handshake on any channel
    localparam int PIPE_DRAIN     = 4;    // items sit in the input and result registers, keep some margin
    localparam int RANDOM_ITEMS   = 800;
    localparam int MAX_SHOWN      = 10;
    localparam int MAX_WAIT       = 14;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    ddcrfc_in_if  in_ch ();
    ddcrfc_out_if out_ch ();
    ddcrfc_cfg_if cfg_ch ();

    ddc_ci_reply_frame_checker dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Frame parser mirror: registers and parse state as the block sees them
    // ------------------------------------------------------------------
    logic [6:0] mdl_dev_addr;
    logic [6:0] mdl_limit;
    t_phase     mdl_phase;
    logic [7:0] mdl_xor;
    logic [6:0] mdl_left;
    logic [6:0] mdl_flen;

    t_result    reply_results_due[$];  // results owed by the block, oldest first
    t_result    next_due;
    logic [7:0] frame_buf[$];          // bytes of the reply being assembled

    int mismatches     = 0;
    int consumed_items = 0;  // bytes the parser actually acts on
    int ready_hold     = 0;  // cycles the result side still holds ready low
    int quiet_cycles   = 0;
    bit send_idle      = 1'b1;
    bit recv_idle      = 1'b1;
    bit full_frame_pending;

    // Status result ends the frame; everything after it is ignored until a start.
    function automatic t_result status_result(input t_status code, input logic [6:0] count);
        t_result r;
        r.out_byte      = 8'h00;
        r.is_status     = 1'b1;
        r.status        = code;
        r.payload_count = count;
        mdl_phase       = PH_DONE;
        return r;
    endfunction

    // Steps the parser mirror by one byte; returns 1 when the byte yields a result.
    function automatic bit parse_reply_byte(input logic [7:0] b, input logic st,
                                            output t_result r);
        logic [6:0] len;
        r   = '0;
        len = b[6:0];
        if (st) begin
            // start always wins: unfinished frame is dropped silently
            mdl_xor  = C_SEED_XOR;
            mdl_left = '0;
            mdl_flen = '0;
            if (b == C_BUSY_A || b == C_BUSY_B) begin
                r = status_result(ST_BUSY, '0);
                return 1'b1;
            end
            if (b != {mdl_dev_addr, 1'b0}) begin
                r = status_result(ST_BAD_SOURCE, '0);
                return 1'b1;
            end
            mdl_xor   = mdl_xor ^ b;
            mdl_phase = PH_LENGTH;
            return 1'b0;
        end
        case (mdl_phase)
            PH_LENGTH: begin
                if (!b[7]) begin
                    r = status_result(ST_NO_FLAG, len);
                    return 1'b1;
                end
                if (len > mdl_limit) begin
                    r = status_result(ST_TOO_LONG, len);
                    return 1'b1;
                end
                mdl_xor   = mdl_xor ^ b;
                mdl_flen  = len;
                mdl_left  = len;
                mdl_phase = (len == 7'd0) ? PH_CHECK : PH_PAYLOAD;
                return 1'b0;
            end
            PH_PAYLOAD: begin
                // payload streams out as it arrives
                mdl_xor  = mdl_xor ^ b;
                mdl_left = mdl_left - 7'd1;
                if (mdl_left == 7'd0) mdl_phase = PH_CHECK;
                r.out_byte = b;
                return 1'b1;
            end
            PH_CHECK: begin
                mdl_xor = mdl_xor ^ b;
                r = status_result((mdl_xor == 8'h00) ? ST_OK : ST_CHECKSUM, mdl_flen);
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Wait before an item: at least a third of the draws give no gap even with idling on.
    function automatic int draw_wait(input bit enabled);
        if (enabled && $urandom_range(0, 2) != 0) return $urandom_range(0, MAX_WAIT);
        return 0;
    endfunction

    // Reply for the current address: source, length, payload, checksum (bad unless good_sum).
    function automatic void build_reply(input int len, input bit good_sum);
        logic [7:0] sum;
        logic [7:0] b;
        frame_buf.delete();
        frame_buf.push_back({mdl_dev_addr, 1'b0});
        frame_buf.push_back(C_LEN_FLAG | 8'(len));
        sum = C_SEED_XOR ^ frame_buf[0] ^ frame_buf[1];
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom_range(0, 255));
            frame_buf.push_back(b);
            sum = sum ^ b;
        end
        if (!good_sum) sum = sum ^ 8'($urandom_range(1, 255));
        frame_buf.push_back(sum);
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------

    // Called at a falling edge, returns at a falling edge. Valid stays high
    // into the next item when that item draws no gap.
    task automatic send_item(input logic [7:0] b, input logic st);
        int      gap;
        t_result r;
        gap = draw_wait(send_idle);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.rx_byte     <= b;
        in_ch.frame_start <= st;
        do @(posedge i_clk); while (!in_ch.ready);
        if (st || (mdl_phase != PH_IDLE && mdl_phase != PH_DONE)) consumed_items++;
        if (parse_reply_byte(b, st, r)) reply_results_due.push_back(r);
        @(negedge i_clk);
    endtask

    task automatic send_frame(input int count);
        for (int i = 0; i < count; i++) send_item(frame_buf[i], i == 0);
    endtask

    // Drops valid, waits for every owed result, then lets the pipe empty of
    // bytes that produce nothing.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (reply_results_due.size() != 0) @(negedge i_clk);
        repeat (PIPE_DRAIN) @(negedge i_clk);
    endtask

    // Leaves valid high; the caller lowers it after the last write.
    task automatic write_register(input logic idx, input logic [7:0] data);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.wr_data   <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (idx == C_REG_DEVICE_ADDRESS) mdl_dev_addr = data[6:0];
        else mdl_limit = data[6:0];
        @(negedge i_clk);
    endtask

    task automatic write_settings(input logic [7:0] addr_data, input logic [7:0] limit_data);
        wait_drained();
        write_register(C_REG_DEVICE_ADDRESS, addr_data);
        write_register(C_REG_PAYLOAD_LIMIT, limit_data);
        cfg_ch.valid <= 1'b0;
    endtask

    // Result side: ready dropped for a random number of cycles after each item.
    always @(negedge i_clk) begin
        if (ready_hold != 0) begin
            out_ch.ready <= 1'b0;
            ready_hold--;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Every accepted result is matched against the oldest owed one.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            ready_hold = draw_wait(recv_idle);
            if (reply_results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected result: byte %02h is_status %0b status %0d count %0d",
                             out_ch.out_byte, out_ch.is_status, out_ch.status,
                             out_ch.payload_count);
            end else begin
                next_due = reply_results_due.pop_front();
                if (out_ch.out_byte !== next_due.out_byte
                        || out_ch.is_status !== next_due.is_status
                        || out_ch.status !== next_due.status
                        || out_ch.payload_count !== next_due.payload_count) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display({"result mismatch: expected byte %02h is_status %0b ",
                                  "status %0d count %0d, got byte %02h is_status %0b ",
                                  "status %0d count %0d"},
                                 next_due.out_byte, next_due.is_status, next_due.status,
                                 next_due.payload_count, out_ch.out_byte,
                                 out_ch.is_status, out_ch.status, out_ch.payload_count);
                end
            end
        end
    end

    // Hang detector: any handshake on any channel restarts the count.
    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                    || (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Header checks at the reset register values (source 0x6E, limit 8).
    task automatic test_header_checks();
        send_item(8'hA5, 1'b0);                    // stray byte while idle
        send_item(C_BUSY_A, 1'b1);
        send_item(C_BUSY_B, 1'b1);
        send_item(8'h00, 1'b1);                    // wrong source
        send_item({mdl_dev_addr, 1'b1}, 1'b1);     // right address, low bit set
        send_item({mdl_dev_addr, 1'b0}, 1'b1);
        send_item(8'h7F, 1'b0);                    // length flag missing
        send_item({mdl_dev_addr, 1'b0}, 1'b1);
        send_item(C_LEN_FLAG | 8'(mdl_limit + 7'd1), 1'b0);  // one past the limit
        send_item(8'hFF, 1'b0);                    // after the frame ended: ignored
    endtask

    task automatic test_payload_framing();
        build_reply(0, 1'b1);                      // empty payload, straight to checksum
        send_frame(3);
        build_reply(3, 1'b1);
        send_frame(6);
        build_reply(2, 1'b1);                      // cut off inside the payload...
        send_frame(3);
        build_reply(1, 1'b0);                      // ...by a new start; bad checksum
        send_frame(4);
    endtask

    // One random reply shape; mostly well-formed, the rest broken or noise.
    task automatic send_random_frame();
        int         kind;
        int         len;
        logic [7:0] b;
        kind = $urandom_range(0, 99);
        if ($urandom_range(0, 19) == 0) len = $urandom_range(0, mdl_limit);
        else len = $urandom_range(0, (mdl_limit < 7'd6) ? mdl_limit : 7'd6);
        if (full_frame_pending) begin
            kind = 0;
            len  = mdl_limit;
            full_frame_pending = 1'b0;
        end
        if (kind < 60) begin
            build_reply(len, $urandom_range(0, 6) != 0);
            send_frame(frame_buf.size());
        end else if (kind < 70) begin
            // truncated: whatever comes next decides what happens
            build_reply(len, 1'b1);
            send_frame($urandom_range(1, frame_buf.size() - 1));
        end else if (kind < 75) begin
            send_item(($urandom_range(0, 1) != 0) ? C_BUSY_A : C_BUSY_B, 1'b1);
        end else if (kind < 80) begin
            b = 8'($urandom_range(0, 255));
            if (b == {mdl_dev_addr, 1'b0}) b = b ^ 8'h02;
            send_item(b, 1'b1);
        end else if (kind < 85) begin
            send_item({mdl_dev_addr, 1'b0}, 1'b1);
            send_item(8'($urandom_range(0, 127)), 1'b0);
        end else if (kind < 90) begin
            send_item({mdl_dev_addr, 1'b0}, 1'b1);
            // nothing can be too long at the top limit; send an unflagged length then
            if (mdl_limit == C_MAX_LEN) send_item(8'(len), 1'b0);
            else send_item(C_LEN_FLAG | 8'($urandom_range(mdl_limit + 1, 127)), 1'b0);
        end else begin
            repeat ($urandom_range(1, 4))
                send_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end
        // occasional byte past the end of the frame
        if ($urandom_range(0, 3) == 0) send_item(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // Settings change between bursts; the first two bursts pin the register
    // extremes, the second with bit 7 set on both writes (must be dropped).
    task automatic test_random_traffic();
        int         burst_no;
        int         start_count;
        logic [6:0] limit_pick;
        burst_no    = 0;
        start_count = consumed_items;
        while (consumed_items - start_count < RANDOM_ITEMS) begin
            case (burst_no)
                0: write_settings(8'h00, 8'h00);
                1: write_settings(8'hFF, 8'hFF);
                default: begin
                    if ($urandom_range(0, 5) == 0) limit_pick = C_MAX_LEN;
                    else limit_pick = 7'($urandom_range(0, 12));
                    write_settings(8'($urandom_range(0, 255)),
                                   {1'($urandom_range(0, 1)), limit_pick});
                end
            endcase
            send_idle = $urandom_range(0, 3) != 0;
            recv_idle = $urandom_range(0, 3) != 0;
            // a burst opens with a reply at the full limit if that is cheap; burst 1 always does
            full_frame_pending = (burst_no == 1) || (mdl_limit < 7'd16);
            repeat ($urandom_range(6, 14)) send_random_frame();
            burst_no++;
        end
    endtask

    initial begin
        in_ch.valid       = 1'b0;
        in_ch.rx_byte     = 8'h00;
        in_ch.frame_start = 1'b0;
        out_ch.ready      = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.reg_index  = C_REG_DEVICE_ADDRESS;
        cfg_ch.wr_data    = 8'h00;
        mdl_dev_addr      = C_DEV_ADDR_RST;
        mdl_limit         = C_PAYLOAD_LIMIT_RST;
        mdl_phase         = PH_IDLE;
        mdl_xor           = C_SEED_XOR;
        mdl_left          = '0;
        mdl_flen          = '0;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_header_checks();
        test_payload_framing();
        test_random_traffic();

        wait_drained();
        mismatches += reply_results_due.size();
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
